[hdl/sst_pkg.sv]
// Package for the scene slot table: command and request codes, store and
// result structs, and the intensity-to-arc-level ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned UID_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SLOT_W    = 7;
  localparam int unsigned SCENE_W   = 6;
  localparam int unsigned PCT_MAX   = 100;
  localparam int unsigned PCT_IDX_W = $clog2(PCT_MAX + 1);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GOTO = 2'd2;

  // command types
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DEL    = 2'd1;
  localparam logic [1:0] CMD_RECALL = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_MISS = 7'h7F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } sst_state_t;

  typedef struct packed {
    logic              en;
    logic [UID_W-1:0]  uid;
    logic [BYTE_W-1:0] ballast;
  } sst_wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic               command_valid;
    logic [1:0]         command_type;
    logic [BYTE_W-1:0]  command_ballast;
    logic [BYTE_W-1:0]  command_level;
    logic [SCENE_W-1:0] command_scene;
    logic [BYTE_W-1:0]  command_source;
  } sst_res_t;

  // trunc(253*(1+log10 p)/3 + 1), zero for p = 0
  localparam logic [BYTE_W-1:0] LEVEL_ROM [0:PCT_MAX] = '{
      8'd0,   8'd85,  8'd110, 8'd125, 8'd136, 8'd144, 8'd150, 8'd156, 8'd161, 8'd165,
      8'd169, 8'd173, 8'd176, 8'd179, 8'd181, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
      8'd195, 8'd196, 8'd198, 8'd200, 8'd201, 8'd203, 8'd204, 8'd206, 8'd207, 8'd208,
      8'd209, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd219,
      8'd220, 8'd221, 8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd226, 8'd227, 8'd227,
      8'd228, 8'd229, 8'd230, 8'd230, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234,
      8'd235, 8'd235, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239, 8'd239, 8'd240,
      8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245,
      8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249,
      8'd250, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253,
      8'd254
  };

  function automatic logic [BYTE_W-1:0] level_of(input logic [BYTE_W-1:0] pct);
    logic [PCT_IDX_W-1:0] p;
    p = (pct > BYTE_W'(PCT_MAX)) ? PCT_IDX_W'(PCT_MAX) : pct[PCT_IDX_W-1:0];
    return LEVEL_ROM[p];
  endfunction

endpackage

`default_nettype wire

[hdl/scene_slot_table_with_level_map.sv]
// Top level of the scene slot table: sequencer, slot store and the result
// register that drives the strobed output transaction.
// Depends on sst_pkg, sst_slot_store and sst_seq.
`timescale 1ns / 1ps
`default_nettype none

// Scene slot table with logarithmic level map.
// A request transaction is taken at a rising edge where start is high and
// busy is low. The block then walks the table one slot a cycle through its
// single memory read port and identifier comparator: a request that hits a
// slot ends the walk at that slot, a miss or a new add walks the whole
// table, and an unused kind code skips the walk. In the first cycle with
// busy low again the result sits on the out_ ports for exactly one cycle,
// marked by out_strobe; there is no
// back-pressure, so capture it then or lose it. A new request may be issued
// in that same strobe cycle. Every request gives exactly one result. A miss,
// a full table or an unused kind code returns slot index -1 with no command
// and all command fields zero. Intensities above 100 percent saturate.
// An identifier of zero matches the first free slot. The table is all free
// straight after reset; no clearing pass is needed.
module scene_slot_table_with_level_map #(
  parameter int unsigned SLOTS = sst_pkg::SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sst_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [sst_pkg::UID_W-1:0]       in_scene_uid,
  input  wire logic [sst_pkg::BYTE_W-1:0]      in_ballast_short_id,
  input  wire logic [sst_pkg::BYTE_W-1:0]      in_intensity_percent,
  input  wire logic [sst_pkg::BYTE_W-1:0]      in_request_source,
  output logic                                 out_strobe,
  output logic signed [sst_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                                 out_command_valid,
  output logic      [1:0]                      out_command_type,
  output logic      [sst_pkg::BYTE_W-1:0]      out_command_ballast,
  output logic      [sst_pkg::BYTE_W-1:0]      out_command_level,
  output logic      [sst_pkg::SCENE_W-1:0]     out_command_scene,
  output logic      [sst_pkg::BYTE_W-1:0]      out_command_source
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [IDX_W-1:0]           rd_idx;
  logic [sst_pkg::UID_W-1:0]  rd_uid;
  logic [sst_pkg::BYTE_W-1:0] rd_ballast;
  logic [IDX_W-1:0]           wr_idx;
  sst_pkg::sst_wr_t           wr;
  logic                       done;
  sst_pkg::sst_res_t          res;
  sst_pkg::sst_res_t          res_r;
  logic                       strobe_r;

  // sequencer owns the search and decides the write
  sst_seq #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .kind              (in_kind),
    .scene_uid         (in_scene_uid),
    .ballast_short_id  (in_ballast_short_id),
    .intensity_percent (in_intensity_percent),
    .request_source    (in_request_source),
    .rd_idx            (rd_idx),
    .rd_uid            (rd_uid),
    .rd_ballast        (rd_ballast),
    .wr_idx            (wr_idx),
    .wr                (wr),
    .done              (done),
    .res               (res)
  );

  sst_slot_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_idx     (rd_idx),
    .rd_uid     (rd_uid),
    .rd_ballast (rd_ballast),
    .wr_idx     (wr_idx),
    .wr         (wr)
  );

  // hold the finished result for its single strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_slot_index      = res_r.slot_index;
  assign out_command_valid   = res_r.command_valid;
  assign out_command_type    = res_r.command_type;
  assign out_command_ballast = res_r.command_ballast;
  assign out_command_level   = res_r.command_level;
  assign out_command_scene   = res_r.command_scene;
  assign out_command_source  = res_r.command_source;

endmodule

`default_nettype wire

[hdl/sst_slot_store.sv]
// Slot store: identifier and short id memories with a registered read port,
// plus per-entry valid bits so that unwritten entries read as zero.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_slot_store #(
  parameter int unsigned SLOTS = sst_pkg::SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [IDX_W-1:0]            rd_idx,
  output logic      [sst_pkg::UID_W-1:0]   rd_uid,
  output logic      [sst_pkg::BYTE_W-1:0]  rd_ballast,
  input  wire logic [IDX_W-1:0]            wr_idx,
  input  wire sst_pkg::sst_wr_t            wr
);

  logic [sst_pkg::UID_W-1:0]  uid_mem     [SLOTS];
  logic [sst_pkg::BYTE_W-1:0] ballast_mem [SLOTS];
  logic [SLOTS-1:0]           vld_r;
  logic [sst_pkg::UID_W-1:0]  rd_uid_r;
  logic [sst_pkg::BYTE_W-1:0] rd_ballast_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      uid_mem[wr_idx]     <= wr.uid;
      ballast_mem[wr_idx] <= wr.ballast;
    end
    rd_uid_r     <= uid_mem[rd_idx];
    rd_ballast_r <= ballast_mem[rd_idx];
    rd_vld_r     <= vld_r[rd_idx];
  end

  // mark an entry as written; reset frees the whole table at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_uid     = rd_vld_r ? rd_uid_r : '0;
  assign rd_ballast = rd_vld_r ? rd_ballast_r : '0;

endmodule

`default_nettype wire

[hdl/sst_seq.sv]
// Search sequencer: walks the slot store one entry a cycle through a single
// identifier comparator, then builds the result and the store write.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_seq #(
  parameter int unsigned SLOTS = sst_pkg::SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sst_pkg::KIND_W-1:0]    kind,
  input  wire logic [sst_pkg::UID_W-1:0]     scene_uid,
  input  wire logic [sst_pkg::BYTE_W-1:0]    ballast_short_id,
  input  wire logic [sst_pkg::BYTE_W-1:0]    intensity_percent,
  input  wire logic [sst_pkg::BYTE_W-1:0]    request_source,
  output logic      [IDX_W-1:0]              rd_idx,
  input  wire logic [sst_pkg::UID_W-1:0]     rd_uid,
  input  wire logic [sst_pkg::BYTE_W-1:0]    rd_ballast,
  output logic      [IDX_W-1:0]              wr_idx,
  output sst_pkg::sst_wr_t                   wr,
  output logic                               done,
  output sst_pkg::sst_res_t                  res
);

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  sst_pkg::sst_state_t state_r, state_nxt;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [IDX_W-1:0]              hit_idx_r, hit_idx_nxt;
  logic [sst_pkg::BYTE_W-1:0]    hit_ballast_r, hit_ballast_nxt;
  logic                          free_r, free_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic [sst_pkg::KIND_W-1:0]    kind_r;
  logic [sst_pkg::UID_W-1:0]     uid_r;
  logic [sst_pkg::BYTE_W-1:0]    shid_r;
  logic [sst_pkg::BYTE_W-1:0]    pct_r;
  logic [sst_pkg::BYTE_W-1:0]    src_r;

  logic accept;
  logic last_issue;
  logic cmp_on;
  logic uid_eq;
  logic uid_free;
  logic sel_ok;
  logic [IDX_W-1:0] sel_idx;

  assign accept     = start && (state_r == sst_pkg::ST_IDLE);
  assign last_issue = (cnt_r == CNT_W'(SLOTS - 1));
  assign cmp_on     = cmp_vld_r &&
                      ((state_r == sst_pkg::ST_SCAN) || (state_r == sst_pkg::ST_DRAIN));
  // the shared comparator
  assign uid_eq     = (rd_uid == uid_r);
  assign uid_free   = (rd_uid == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (kind > sst_pkg::KIND_GOTO) ? sst_pkg::ST_FINISH : sst_pkg::ST_SCAN;
        end
      end
      sst_pkg::ST_SCAN: begin
        if (cmp_on && uid_eq) begin
          state_nxt = sst_pkg::ST_FINISH;
        end else if (last_issue) begin
          state_nxt = sst_pkg::ST_DRAIN;
        end
      end
      sst_pkg::ST_DRAIN:  state_nxt = sst_pkg::ST_FINISH;
      sst_pkg::ST_FINISH: state_nxt = sst_pkg::ST_IDLE;
      default:            state_nxt = sst_pkg::ST_IDLE;
    endcase
  end

  // search datapath
  always_comb begin
    cnt_nxt         = cnt_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_ballast_nxt = hit_ballast_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    if (accept) begin
      cnt_nxt  = '0;
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end
    if (state_r == sst_pkg::ST_SCAN) begin
      cmp_vld_nxt = 1'b1;
      cmp_idx_nxt = cnt_r[IDX_W-1:0];
      cnt_nxt     = cnt_r + CNT_W'(1);
    end
    if (cmp_on) begin
      if (uid_eq) begin
        hit_nxt         = 1'b1;
        hit_idx_nxt     = cmp_idx_r;
        hit_ballast_nxt = rd_ballast;
      end
      if (uid_free && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  // outputs
  always_comb begin
    busy    = (state_r != sst_pkg::ST_IDLE);
    rd_idx  = cnt_r[IDX_W-1:0];
    done    = (state_r == sst_pkg::ST_FINISH);
    sel_ok  = 1'b0;
    sel_idx = hit_idx_r;
    if (hit_r) begin
      sel_ok = 1'b1;
    end else if ((kind_r == sst_pkg::KIND_ADD) && free_r) begin
      sel_ok  = 1'b1;
      sel_idx = free_idx_r;
    end
    wr_idx     = sel_idx;
    wr.en      = 1'b0;
    wr.uid     = '0;
    wr.ballast = '0;
    res        = '0;
    res.slot_index = sst_pkg::SLOT_MISS;
    if (sel_ok) begin
      res.slot_index    = sst_pkg::SLOT_W'(sel_idx);
      res.command_valid = 1'b1;
      res.command_scene = sst_pkg::SCENE_W'(sel_idx);
      unique case (kind_r)
        sst_pkg::KIND_ADD: begin
          wr.en               = done;
          wr.uid              = uid_r;
          wr.ballast          = shid_r;
          res.command_type    = sst_pkg::CMD_ADD;
          res.command_ballast = shid_r;
          res.command_level   = sst_pkg::level_of(pct_r);
        end
        sst_pkg::KIND_DEL: begin
          wr.en               = done;
          res.command_type    = sst_pkg::CMD_DEL;
          res.command_ballast = hit_ballast_r;
          res.command_level   = sst_pkg::level_of(pct_r);
        end
        sst_pkg::KIND_GOTO: begin
          res.command_type    = sst_pkg::CMD_RECALL;
          res.command_ballast = hit_ballast_r;
          res.command_source  = src_r;
        end
        default: begin
          res = '0;
          res.slot_index = sst_pkg::SLOT_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sst_pkg::ST_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_ballast_r <= hit_ballast_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    if (accept) begin
      kind_r <= kind;
      uid_r  <= scene_uid;
      shid_r <= ballast_short_id;
      pct_r  <= intensity_percent;
      src_r  <= request_source;
    end
  end

endmodule

`default_nettype wire
